// File: design/bcv_pkg.sv
`default_nettype none

package bcv_pkg;

    // serial multiplier: product width, iterated operand width, bit counter
    localparam int PROD_W = 90;
    localparam int MB_W   = 41;
    localparam int MCNT_W = 6;

    // serial divider: dividend and divisor widths, bit counter
    localparam int DIV_W  = 52;
    localparam int DVS_W  = 32;
    localparam int DCNT_W = 6;

    // configuration register indexes
    localparam logic [2:0] CFG_CONSTANT_COEF  = 3'd0;
    localparam logic [2:0] CFG_LINEAR_COEF    = 3'd1;
    localparam logic [2:0] CFG_CAPACITY       = 3'd2;
    localparam logic [2:0] CFG_RESISTANCE     = 3'd3;
    localparam logic [2:0] CFG_SMOOTHING_GAIN = 3'd4;
    localparam logic [2:0] CFG_STEP_HOURS     = 3'd5;
    localparam logic [2:0] CFG_CHARGE_RATE    = 3'd6;

    // input actions
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_CUR,
        ST_MUL_SMOOTH,
        ST_MUL_STEP,
        ST_DIV_RATIO,
        ST_MUL_LIN,
        ST_MUL_RES,
        ST_MUL_SCALE,
        ST_MUL_ENERGY,
        ST_OUT
    } bcv_state_t;

    typedef struct packed {
        logic                     start;
        logic signed [PROD_W-1:0] a;
        logic [MB_W-1:0]          b;
        logic [MCNT_W-1:0]        n;
    } mul_req_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } div_req_t;

endpackage

`default_nettype wire

// File: design/battery_charge_voltage_model.sv
`default_nettype none

// Linear battery model with coulomb counting. A tick item turns load power and
// battery voltage into a current (serial divide), smooths it, moves the stored
// charge, and reports terminal voltage from the unclamped charge (second serial
// divide, by the capacity), the clamped charge and the energy. All products go
// through one shift-add multiplier taking one bit per cycle, so a tick occupies
// the block through the two serial divides and six serial multiplies in turn.
// A load item or a tick with battery voltage magnitude of 65 LSB or less skips
// the arithmetic and passes from the transfer through the output state into
// the output register. One item is worked at a time; the next is taken while
// the previous result waits in the output register. Configuration writes take
// effect at once and belong in idle time.
module battery_charge_voltage_model
    import bcv_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [39:0]        cfg_wr_data,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic signed [31:0] s_total_power,
    input  wire logic signed [31:0] s_battery_voltage,
    input  wire logic               s_charging_on,
    input  wire logic signed [47:0] s_new_charge,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_terminal_voltage,
    output logic signed [47:0]      m_charge,
    output logic signed [47:0]      m_energy_mwh,
    output logic                    m_charge_empty,
    output logic                    m_voltage_too_low
);

    // configuration registers
    logic signed [31:0] constant_coef_reg;
    logic signed [31:0] linear_coef_reg;
    logic [30:0]        capacity_reg;
    logic [30:0]        resistance_reg;
    logic [16:0]        smoothing_gain_reg;
    logic [39:0]        step_hours_reg;
    logic signed [31:0] charge_rate_reg;

    // control and model state
    bcv_state_t         state_reg, state_next;
    logic               issue_reg, issue_next;
    logic signed [31:0] sm_reg;
    logic signed [47:0] stored_reg;

    // item and intermediate values
    logic signed [31:0] p_reg;
    logic signed [31:0] v_reg;
    logic               charging_reg;
    logic signed [31:0] cur_reg;
    logic signed [51:0] qraw_reg;
    logic signed [52:0] ratio_reg;
    logic signed [71:0] term_reg;
    logic signed [31:0] et_reg;
    logic signed [57:0] qm_reg;
    logic signed [31:0] res_tv_reg;
    logic signed [47:0] res_energy_reg;
    logic               res_low_reg;

    // output register
    logic               m_valid_reg;
    logic signed [31:0] m_tv_reg;
    logic signed [47:0] m_charge_reg;
    logic signed [47:0] m_energy_reg;
    logic               m_empty_reg;
    logic               m_low_reg;

    // datapath units
    mul_req_t                 mul_req;
    div_req_t                 div_req;
    logic                     mul_busy, mul_done;
    logic                     div_busy, div_done;
    logic signed [PROD_W-1:0] product;
    logic [DIV_W-1:0]         quotient;

    logic               accept;
    logic               out_free;
    logic [30:0]        cap_eff;
    logic signed [47:0] capq;
    logic               low_voltage;
    logic [31:0]        p_abs;
    logic [31:0]        v_abs;
    logic signed [52:0] num;
    logic signed [52:0] cur_signed;
    logic signed [47:0] qf;
    logic signed [31:0] et;

    function automatic logic signed [31:0] sat32(input logic signed [73:0] x);
        logic signed [31:0] r;
        if (x > 74'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -74'sh0_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [59:0] x);
        logic signed [47:0] r;
        if (x > 60'sh0_7FFF_FFFF_FFFF) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (x < -60'sh0_8000_0000_0000) begin
            r = -48'sh8000_0000_0000;
        end else begin
            r = x[47:0];
        end
        return r;
    endfunction

    bcv_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (product)
    );

    bcv_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // handshake and shared terms
    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign cap_eff     = (capacity_reg == '0) ? 31'd1 : capacity_reg;
    assign capq        = {1'b0, cap_eff, 16'b0};
    assign low_voltage = (s_battery_voltage <= 32'sd65) && (s_battery_voltage >= -32'sd65);
    assign p_abs       = p_reg[31] ? 32'(-p_reg) : 32'(p_reg);
    assign v_abs       = v_reg[31] ? 32'(-v_reg) : 32'(v_reg);
    assign num         = 53'(capq) - 53'(qraw_reg);
    assign cur_signed  = (p_reg[31] ^ v_reg[31]) ? -$signed({1'b0, quotient})
                                                 : $signed({1'b0, quotient});

    // charge clamp and terminal voltage, taken when the resistance product lands
    always_comb begin
        if (qraw_reg > 52'(capq)) begin
            qf = capq;
        end else if (qraw_reg < -52'sh8000_0000_0000) begin
            qf = -48'sh8000_0000_0000;
        end else begin
            qf = qraw_reg[47:0];
        end
    end

    assign et = sat32(74'(constant_coef_reg) + 74'(term_reg)
                      - 74'($signed(product[63:16])));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACT_LOAD || low_voltage) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_DIV_CUR;
                    end
                end
            end
            ST_DIV_CUR:    if (div_done) state_next = ST_MUL_SMOOTH;
            ST_MUL_SMOOTH: if (mul_done) state_next = ST_MUL_STEP;
            ST_MUL_STEP:   if (mul_done) state_next = ST_DIV_RATIO;
            ST_DIV_RATIO:  if (div_done) state_next = ST_MUL_LIN;
            ST_MUL_LIN:    if (mul_done) state_next = ST_MUL_RES;
            ST_MUL_RES:    if (mul_done) state_next = ST_MUL_SCALE;
            ST_MUL_SCALE:  if (mul_done) state_next = ST_MUL_ENERGY;
            ST_MUL_ENERGY: if (mul_done) state_next = ST_OUT;
            ST_OUT:        if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // a unit is started in the first cycle of each working state
    assign issue_next = (state_next != state_reg) && (state_next != ST_IDLE)
                        && (state_next != ST_OUT);

    // unit requests
    always_comb begin
        mul_req = '0;
        div_req = '0;
        unique case (state_reg)
            ST_DIV_CUR: begin
                div_req.start    = issue_reg;
                div_req.dividend = {4'b0, p_abs, 16'b0};
                div_req.divisor  = v_abs;
            end
            ST_MUL_SMOOTH: begin
                mul_req.start = issue_reg;
                mul_req.a     = PROD_W'(33'(cur_reg) - 33'(sm_reg));
                mul_req.b     = MB_W'(smoothing_gain_reg);
                mul_req.n     = MCNT_W'(18);
            end
            ST_MUL_STEP: begin
                mul_req.start = issue_reg;
                mul_req.a     = charging_reg ? PROD_W'(charge_rate_reg) : PROD_W'(sm_reg);
                mul_req.b     = MB_W'(step_hours_reg);
                mul_req.n     = MCNT_W'(41);
            end
            ST_DIV_RATIO: begin
                div_req.start    = issue_reg;
                div_req.dividend = num[52] ? DIV_W'(~num) : DIV_W'(num);
                div_req.divisor  = DVS_W'(cap_eff);
            end
            ST_MUL_LIN: begin
                mul_req.start = issue_reg;
                mul_req.a     = PROD_W'(ratio_reg);
                mul_req.b     = MB_W'(unsigned'(linear_coef_reg));
                mul_req.n     = MCNT_W'(32);
            end
            ST_MUL_RES: begin
                mul_req.start = issue_reg;
                mul_req.a     = PROD_W'(sm_reg);
                mul_req.b     = MB_W'(resistance_reg);
                mul_req.n     = MCNT_W'(32);
            end
            ST_MUL_SCALE: begin
                mul_req.start = issue_reg;
                mul_req.a     = PROD_W'(stored_reg);
                mul_req.b     = MB_W'(1000);
                mul_req.n     = MCNT_W'(11);
            end
            ST_MUL_ENERGY: begin
                mul_req.start = issue_reg;
                mul_req.a     = PROD_W'(qm_reg);
                mul_req.b     = MB_W'(unsigned'(et_reg));
                mul_req.n     = MCNT_W'(32);
            end
            default: begin
                mul_req = '0;
                div_req = '0;
            end
        endcase
    end

    // control state, model state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            issue_reg          <= 1'b0;
            sm_reg             <= '0;
            stored_reg         <= '0;
            m_valid_reg        <= 1'b0;
            constant_coef_reg  <= '0;
            linear_coef_reg    <= '0;
            capacity_reg       <= 31'd65536;
            resistance_reg     <= '0;
            smoothing_gain_reg <= '0;
            step_hours_reg     <= '0;
            charge_rate_reg    <= '0;
        end else begin
            state_reg <= state_next;
            issue_reg <= issue_next;

            if (accept && s_action == ACT_LOAD) begin
                stored_reg <= (s_new_charge > capq) ? capq : s_new_charge;
            end else if (state_reg == ST_MUL_RES && mul_done) begin
                stored_reg <= qf;
            end
            if (state_reg == ST_MUL_SMOOTH && mul_done) begin
                sm_reg <= sat32(74'(sm_reg) + 74'($signed(product[51:16])));
            end

            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_CONSTANT_COEF:  constant_coef_reg  <= cfg_wr_data[31:0];
                    CFG_LINEAR_COEF:    linear_coef_reg    <= cfg_wr_data[31:0];
                    CFG_CAPACITY:       capacity_reg       <= cfg_wr_data[30:0];
                    CFG_RESISTANCE:     resistance_reg     <= cfg_wr_data[30:0];
                    CFG_SMOOTHING_GAIN: smoothing_gain_reg <= cfg_wr_data[16:0];
                    CFG_STEP_HOURS:     step_hours_reg     <= cfg_wr_data[39:0];
                    CFG_CHARGE_RATE:    charge_rate_reg    <= cfg_wr_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    // item capture and intermediate results
    always_ff @(posedge aclk) begin
        if (accept) begin
            p_reg          <= s_total_power;
            v_reg          <= s_battery_voltage;
            charging_reg   <= s_charging_on;
            res_tv_reg     <= '0;
            res_energy_reg <= '0;
            res_low_reg    <= (s_action == ACT_TICK) && low_voltage;
        end
        if (state_reg == ST_DIV_CUR && div_done) begin
            cur_reg <= sat32(74'(cur_signed));
        end
        if (state_reg == ST_MUL_STEP && mul_done) begin
            qraw_reg <= charging_reg ? 52'(stored_reg) + $signed(product[75:24])
                                     : 52'(stored_reg) - $signed(product[75:24]);
        end
        if (state_reg == ST_DIV_RATIO && div_done) begin
            ratio_reg <= num[52] ? ~$signed({1'b0, quotient}) : $signed({1'b0, quotient});
        end
        if (state_reg == ST_MUL_LIN && mul_done) begin
            term_reg <= $signed(product[87:16]);
        end
        if (state_reg == ST_MUL_RES && mul_done) begin
            et_reg <= et;
        end
        if (state_reg == ST_MUL_SCALE && mul_done) begin
            qm_reg <= product[57:0];
        end
        if (state_reg == ST_MUL_ENERGY && mul_done) begin
            res_tv_reg     <= et_reg;
            res_energy_reg <= sat48(60'($signed(product[89:32])));
        end
    end

    // output register load
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_tv_reg     <= res_tv_reg;
            m_charge_reg <= stored_reg;
            m_energy_reg <= res_energy_reg;
            m_empty_reg  <= (stored_reg <= 48'sd0);
            m_low_reg    <= res_low_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_terminal_voltage = m_tv_reg;
    assign m_charge           = m_charge_reg;
    assign m_energy_mwh       = m_energy_reg;
    assign m_charge_empty     = m_empty_reg;
    assign m_voltage_too_low  = m_low_reg;

`ifndef SYNTHESIS
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({mul_busy, div_busy}))
        else $error("multiplier and divider busy together");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_charge_empty == (m_charge <= 48'sd0)))
        else $error("charge_empty disagrees with charge");

    a_low_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_voltage_too_low) |-> (m_terminal_voltage == '0 && m_energy_mwh == '0))
        else $error("low voltage result carries non-zero values");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_busy || div_busy) |-> !s_ready)
        else $error("input taken while arithmetic in flight");
`endif

endmodule

`default_nettype wire

// File: design/bcv_serial_mul.sv
`default_nettype none

module bcv_serial_mul
    import bcv_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire mul_req_t                 req,
    output logic                          busy,
    output logic                          done,
    output logic signed [PROD_W-1:0]      product
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] a_reg;
    logic [MB_W-1:0]          b_reg;
    logic [MCNT_W-1:0]        cnt_reg;
    logic [MCNT_W-1:0]        n_reg;
    logic                     last;
    logic signed [PROD_W-1:0] acc_step;

    // top bit of the iterated operand carries negative weight
    assign last     = (cnt_reg == n_reg - MCNT_W'(1));
    assign acc_step = last ? (acc_reg - a_reg) : (acc_reg + a_reg);

    // control
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
        end else if (busy_reg && last) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // shift-add datapath, one multiplier bit per cycle
    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg <= '0;
            a_reg   <= req.a;
            b_reg   <= req.b;
            n_reg   <= req.n;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_reg <= acc_step;
            end
            a_reg   <= a_reg <<< 1;
            b_reg   <= b_reg >> 1;
            cnt_reg <= cnt_reg + MCNT_W'(1);
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// File: design/bcv_serial_div.sv
`default_nettype none

module bcv_serial_div
    import bcv_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire div_req_t          req,
    output logic                   busy,
    output logic                   done,
    output logic [DIV_W-1:0]       quotient
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DVS_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [DVS_W-1:0]   d_reg;
    logic [DCNT_W-1:0]  cnt_reg;
    logic               last;
    logic [DVS_W:0]     trial;
    logic               fits;

    // restoring step: one quotient bit per cycle
    assign last  = (cnt_reg == DCNT_W'(DIV_W - 1));
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, d_reg});

    // control
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
        end else if (busy_reg && last) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // dividend shifts out of the top while quotient bits enter at the bottom
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            d_reg   <= req.divisor;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? DVS_W'(trial - {1'b0, d_reg}) : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            cnt_reg <= cnt_reg + DCNT_W'(1);
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: verif/battery_charge_voltage_model_tb.sv
`default_nettype none

module battery_charge_voltage_model_tb
    import bcv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint I32MAX = 64'sd2147483647;
    localparam longint I32MIN = -64'sd2147483648;
    localparam longint I48MAX = 64'sd140737488355327;
    localparam longint I48MIN = -64'sd140737488355328;
    localparam longint PROD_LIM = 64'sd4611686018427387904;
    localparam int STALL_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = CFG_CONSTANT_COEF;
    logic [39:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = ACT_TICK;
    logic signed [31:0] s_total_power = '0;
    logic signed [31:0] s_battery_voltage = '0;
    logic s_charging_on = 1'b0;
    logic signed [47:0] s_new_charge = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_terminal_voltage;
    logic signed [47:0] m_charge;
    logic signed [47:0] m_energy_mwh;
    logic m_charge_empty;
    logic m_voltage_too_low;

    typedef struct packed {
        logic signed [31:0] volts;
        logic signed [47:0] charge;
        logic signed [47:0] energy;
        logic empty;
        logic low;
    } battery_result_t;

    // model copy of the registers and state
    longint e0, e1, cap_reg, res_reg, gain_reg, hours_reg, rate_reg;
    longint i_smooth, q_stored;
    battery_result_t expected_q[$];
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_low = 0;
    int n_load = 0;
    int stall = 0;
    bit quiet = 1'b0;
    bit done = 1'b0;

    always #6 aclk = ~aclk;

    battery_charge_voltage_model u_dut (.*);

    function automatic longint fshr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint fdiv(longint n, longint d);
        if (n >= 0) return n / d;
        return -1 - ((-1 - n) / d);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mul_capped(longint a, longint b);
        longint ua, ub;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        if (ua != 0 && ub > PROD_LIM / ua)
            return ((a < 0) != (b < 0)) ? -PROD_LIM : PROD_LIM;
        return a * b;
    endfunction

    // charge moved in one step: floor(x * hours / 2^24)
    function automatic longint charge_step(longint x, longint hours);
        longint hi, lo, a, aq, ar;
        hi = hours >> 20;
        lo = hours & 64'hFFFFF;
        a = x * hi;
        aq = fshr(a, 4);
        ar = a - aq * 16;
        return aq + fshr(ar * 1048576 + x * lo, 24);
    endfunction

    function automatic battery_result_t make_res(longint v, longint q, longint e, bit low);
        battery_result_t r;
        r.volts = v[31:0];
        r.charge = q[47:0];
        r.energy = e[47:0];
        r.empty = q <= 0;
        r.low = low;
        return r;
    endfunction

    function automatic battery_result_t battery_predict(bit act, longint p, longint v,
                                                      bit chg, longint nq);
        longint capq, c, cur, q, ratio, rh, rl, term, et, qm, e;
        capq = (cap_reg == 0 ? 1 : cap_reg) * 65536;
        c = capq / 65536;
        if (act == ACT_LOAD) begin
            q = nq > capq ? capq : nq;
            q_stored = q;
            return make_res(0, q, 0, 1'b0);
        end
        if (v <= 65 && v >= -65)
            return make_res(0, q_stored, 0, 1'b1);
        cur = clamp((p * 65536) / v, I32MIN, I32MAX);
        i_smooth = clamp(i_smooth + fshr(gain_reg * (cur - i_smooth), 16), I32MIN, I32MAX);
        if (chg) q = q_stored + charge_step(rate_reg, hours_reg);
        else q = q_stored - charge_step(i_smooth, hours_reg);
        ratio = fdiv(capq - q, c);
        rh = fshr(ratio, 16);
        rl = ratio & 64'hFFFF;
        term = mul_capped(e1, rh) + fshr(e1 * rl, 16);
        et = clamp(e0 + term - fshr(res_reg * i_smooth, 16), I32MIN, I32MAX);
        if (q > capq) q = capq;
        q = clamp(q, I48MIN, I48MAX);
        q_stored = q;
        qm = q * 1000;
        e = fshr(qm, 32) * et + fshr((qm & 64'hFFFFFFFF) * et, 32);
        return make_res(et, q, clamp(e, I48MIN, I48MAX), 1'b0);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic write_reg(logic [2:0] idx, longint val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val[39:0];
        case (idx)
            CFG_CONSTANT_COEF:  e0 = longint'(signed'(val[31:0]));
            CFG_LINEAR_COEF:    e1 = longint'(signed'(val[31:0]));
            CFG_CAPACITY:       cap_reg = val & 64'h7FFFFFFF;
            CFG_RESISTANCE:     res_reg = val & 64'h7FFFFFFF;
            CFG_SMOOTHING_GAIN: gain_reg = val & 64'h1FFFF;
            CFG_STEP_HOURS:     hours_reg = val & 64'hFF_FFFFFFFF;
            default:            rate_reg = longint'(signed'(val[31:0]));
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // drain all outstanding results before touching the registers
    task automatic settle();
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    task automatic send_item(bit act, longint p, longint v, bit chg, longint nq);
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < 19) @(negedge aclk);
        s_valid <= 1'b1;
        s_action <= act;
        s_total_power <= p[31:0];
        s_battery_voltage <= v[31:0];
        s_charging_on <= chg;
        s_new_charge <= nq[47:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(battery_predict(act, longint'(signed'(p[31:0])),
            longint'(signed'(v[31:0])), chg, longint'(signed'(nq[47:0]))));
        n_items++;
        if (act == ACT_LOAD) n_load++;
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    function automatic longint rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // result checker
    always @(posedge aclk) begin
        battery_result_t w;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, results so far", n_results, 0);
            end else begin
                w = expected_q.pop_front();
                if (w.low) n_low++;
                if (m_terminal_voltage !== w.volts)
                    report_mismatch("terminal_voltage", m_terminal_voltage, w.volts);
                if (m_charge !== w.charge) report_mismatch("charge", m_charge, w.charge);
                if (m_energy_mwh !== w.energy)
                    report_mismatch("energy_mwh", m_energy_mwh, w.energy);
                if (m_charge_empty !== w.empty)
                    report_mismatch("charge_empty", m_charge_empty, w.empty);
                if (m_voltage_too_low !== w.low)
                    report_mismatch("voltage_too_low", m_voltage_too_low, w.low);
            end
        end
    end

    // receiver stalls
    always @(negedge aclk) m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 19);

    // watchdog on transfers
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || done) stall <= 0;
        else if (stall >= STALL_LIMIT) begin
            $display("battery_charge_voltage_model_tb failed");
            $finish;
        end else stall <= stall + 1;
    end

    task automatic test_reset_defaults();
        send_item(ACT_TICK, 32'sd65536, 32'sd65536, 1'b0, 0);
        send_item(ACT_TICK, 32'sd1, 32'sd65, 1'b0, 0);
        send_item(ACT_TICK, 32'sd1, -32'sd65, 1'b0, 0);
        send_item(ACT_TICK, 32'sd1, 32'sd66, 1'b0, 0);
        send_item(ACT_TICK, 32'sd1, -32'sd66, 1'b1, 0);
    endtask

    task automatic test_register_extremes();
        settle();
        write_reg(CFG_CONSTANT_COEF, 12 * 65536);
        write_reg(CFG_LINEAR_COEF, 2 * 65536);
        write_reg(CFG_CAPACITY, 2 * 65536);
        write_reg(CFG_RESISTANCE, 6554);
        write_reg(CFG_SMOOTHING_GAIN, 6554);
        write_reg(CFG_STEP_HOURS, 40'd305419896);
        write_reg(CFG_CHARGE_RATE, 65536);
        send_item(ACT_LOAD, 0, 0, 1'b0, 64'sd8589934592);
        send_item(ACT_TICK, 100 * 65536, 12 * 65536, 1'b0, 0);
        send_item(ACT_TICK, 100 * 65536, 12 * 65536, 1'b1, 0);
        send_item(ACT_LOAD, 0, 0, 1'b0, I48MAX);
        send_item(ACT_LOAD, 0, 0, 1'b0, I48MIN);
        send_item(ACT_TICK, I32MIN, 32'sd66, 1'b0, 0);
        send_item(ACT_TICK, I32MAX, -32'sd66, 1'b0, 0);
        send_item(ACT_TICK, I32MIN, -32'sd1 <<< 31, 1'b0, 0);
        settle();
        // extremes: zero capacity, gain above one, full step, extreme coefficients
        write_reg(CFG_CAPACITY, 0);
        write_reg(CFG_SMOOTHING_GAIN, 64'h1FFFF);
        write_reg(CFG_STEP_HOURS, 64'hFF_FFFFFFFF);
        write_reg(CFG_CONSTANT_COEF, I32MAX);
        write_reg(CFG_LINEAR_COEF, I32MIN);
        write_reg(CFG_RESISTANCE, 64'h7FFFFFFF);
        write_reg(CFG_CHARGE_RATE, I32MIN);
        send_item(ACT_LOAD, 0, 0, 1'b0, 64'sd100);
        send_item(ACT_TICK, I32MAX, 32'sd70, 1'b0, 0);
        send_item(ACT_TICK, I32MIN, 32'sd70, 1'b1, 0);
        send_item(ACT_TICK, I32MAX, I32MAX, 1'b0, 0);
        send_item(ACT_TICK, 0, I32MIN, 1'b1, 0);
        send_item(ACT_LOAD, 0, 0, 1'b1, -64'sd1);
    endtask

    task automatic test_random(int n);
        longint v, nq;
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            write_reg(CFG_CONSTANT_COEF, ph == 5 ? rnd64() : $urandom_range(20, 1) * 65536);
            write_reg(CFG_LINEAR_COEF, ph == 5 ? rnd64() : $urandom_range(6 * 65536));
            write_reg(CFG_CAPACITY, ph == 4 ? rnd64() : $urandom_range(50 * 65536, 1));
            write_reg(CFG_RESISTANCE, ph == 4 ? rnd64() : $urandom_range(30000));
            write_reg(CFG_SMOOTHING_GAIN, ph == 3 ? rnd64() : $urandom_range(65536));
            write_reg(CFG_STEP_HOURS, ph == 3 ? rnd64() : $urandom_range(1 << 30));
            write_reg(CFG_CHARGE_RATE, ph == 5 ? rnd64() : $urandom_range(5 * 65536));
            quiet = (ph == 2);
            for (int i = 0; i < n / 6; i++) begin
                case ($urandom_range(9))
                    0: v = $urandom_range(130) - 65;
                    1, 2: v = longint'(signed'($urandom()));
                    default: v = $urandom_range(30 * 65536, 65536);
                endcase
                nq = $urandom_range(3) == 0 ? rnd64()
                     : longint'($urandom_range(60 * 65536)) <<< 16;
                if ($urandom_range(14) == 0)
                    send_item(ACT_LOAD, rnd64(), rnd64(), $urandom_range(1), nq);
                else if ($urandom_range(4) == 0)
                    send_item(ACT_TICK, rnd64(), v, $urandom_range(1), rnd64());
                else
                    send_item(ACT_TICK, $urandom_range(300 * 65536), v,
                              $urandom_range(3) == 0, rnd64());
            end
            quiet = 1'b0;
        end
    endtask

    initial begin
        e0 = 0; e1 = 0; cap_reg = 65536; res_reg = 0;
        gain_reg = 0; hours_reg = 0; rate_reg = 0;
        i_smooth = 0; q_stored = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_random(1920);
        settle();
        done = 1'b1;
        $display("covered reset defaults, register extremes and random ticks over six setups");
        $display("%0d items sent (%0d charge loads), %0d results checked, %0d low-voltage skips",
                 n_items, n_load, n_results, n_low);
        if (errors == 0 && expected_q.size() == 0)
            $display("battery_charge_voltage_model_tb passed");
        else
            $display("battery_charge_voltage_model_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
